FILE: src/ltl_pkg.sv
// Shared types, constants and state codes for the landing throttle law.
package ltl_pkg;

  localparam logic [30:0] ONE                 = 31'd65536;
  localparam logic [31:0] GRAV                = 32'd642689;
  localparam logic [30:0] MASS_MIN            = 31'd1802240;
  localparam logic [30:0] MASS_MAX            = 31'd2293760;
  localparam logic [30:0] PASCAL_LIMIT        = 31'd2560000;
  // ceil(2^48 / 100000); the product shifted down by 48 is exact for any 31-bit reading.
  localparam logic [31:0] PASCAL_RECIP        = 32'd2814749768;
  localparam logic [30:0] PRESSURE_MAX_VALID  = 31'd20480;
  localparam logic [31:0] REFERENCE_SPEED_MAX = 32'd3276800;
  localparam logic [16:0] VALVE_COMMAND_LIMIT = 17'd65536;

  localparam int DIV_W  = 48;
  localparam int ROOT_W = 64;

  typedef enum logic [2:0] {
    CFG_TOUCHDOWN_CG_HEIGHT = 3'd0,
    CFG_SHUTDOWN_HEIGHT     = 3'd1,
    CFG_SHUTDOWN_SPEED      = 3'd2,
    CFG_TOUCHDOWN_SPEED     = 3'd3,
    CFG_PROFILE_DECEL       = 3'd4,
    CFG_SPEED_GAIN          = 3'd5,
    CFG_RATED_FORCE         = 3'd6,
    CFG_RATED_PRESSURE      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [30:0] touchdown_cg_height;
    logic [30:0] shutdown_height;
    logic [30:0] shutdown_speed;
    logic [30:0] touchdown_speed;
    logic [30:0] profile_decel;
    logic [30:0] speed_gain;
    logic [30:0] rated_force;
    logic [30:0] rated_pressure;
  } cfg_t;

  typedef struct packed {
    logic [30:0] height;
    logic [30:0] speed;
    logic [21:0] mass;
    logic [30:0] pressure;
    logic        pascal;
    logic        shutdown;
  } item_t;

  typedef struct packed {
    logic [16:0]        valve_command;
    logic               output_valid;
    logic [30:0]        available_force;
    logic [30:0]        height_above_touchdown;
    logic [30:0]        downward_speed;
    logic [30:0]        reference_speed;
    logic signed [31:0] speed_error;
    logic signed [31:0] commanded_accel;
    logic [30:0]        required_force;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PDIV, ST_FMUL, ST_FDIV, ST_CHECK, ST_SQMUL, ST_TWMUL,
    ST_ROOT, ST_AMUL, ST_ADIV, ST_RMUL, ST_VDIV, ST_DONE
  } st_t;

endpackage

FILE: src/landing_throttle_law.sv
// Landing throttle law: derives thrust, reference speed and valve command per sample.
// Samples enter through a two-deep queue and results leave through another, so
// both sides stall independently. The shortest path (pressure at or above the
// rated value and an early exit at the check) uses neither the shared divider
// nor the square root; the longest runs the divider up to three times per
// sample plus the square root, and a pascal reading adds a reciprocal multiply.
// A new sample is accepted while earlier results wait.
module landing_throttle_law (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] cg_height,
  input  logic signed [31:0] vertical_velocity,
  input  logic signed [31:0] vehicle_mass,
  input  logic signed [31:0] supply_pressure,
  output logic               empty,
  input  logic               pop,
  output logic [16:0]        valve_command,
  output logic               output_valid,
  output logic [30:0]        available_force,
  output logic [30:0]        height_above_touchdown,
  output logic [30:0]        downward_speed,
  output logic [30:0]        reference_speed,
  output logic signed [31:0] speed_error,
  output logic signed [31:0] commanded_accel,
  output logic [30:0]        required_force,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import ltl_pkg::*;

  cfg_t                       cfg;
  logic                       q_pop, q_empty, out_push, out_full;
  item_t                      q_item;
  result_t                    res_in, res_out;
  logic [$bits(result_t)-1:0] res_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touchdown_cg_height <= 31'd32768;
      cfg.shutdown_height     <= 31'd3277;
      cfg.shutdown_speed      <= 31'd19661;
      cfg.touchdown_speed     <= 31'd65536;
      cfg.profile_decel       <= 31'd196608;
      cfg.speed_gain          <= 31'd65536;
      cfg.rated_force         <= 31'd39321600;
      cfg.rated_pressure      <= 31'd12800;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOUCHDOWN_CG_HEIGHT: cfg.touchdown_cg_height <= cfg_data;
        CFG_SHUTDOWN_HEIGHT:     cfg.shutdown_height     <= cfg_data;
        CFG_SHUTDOWN_SPEED:      cfg.shutdown_speed      <= cfg_data;
        CFG_TOUCHDOWN_SPEED:     cfg.touchdown_speed     <= cfg_data;
        CFG_PROFILE_DECEL:       cfg.profile_decel       <= cfg_data;
        CFG_SPEED_GAIN:          cfg.speed_gain          <= cfg_data;
        CFG_RATED_FORCE:         cfg.rated_force         <= cfg_data;
        CFG_RATED_PRESSURE:      cfg.rated_pressure      <= cfg_data;
        default: ;
      endcase
    end
  end

  ltl_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .push              (push),
    .full              (full),
    .cg_height         (cg_height),
    .vertical_velocity (vertical_velocity),
    .vehicle_mass      (vehicle_mass),
    .supply_pressure   (supply_pressure),
    .q_pop             (q_pop),
    .q_empty           (q_empty),
    .q_item            (q_item)
  );

  ltl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_res  (res_in)
  );

  ltl_fifo #(.WIDTH($bits(result_t))) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (res_in),
    .full  (out_full),
    .pop   (pop),
    .rdata (res_vec),
    .empty (empty)
  );

  assign res_out                = result_t'(res_vec);
  assign valve_command          = res_out.valve_command;
  assign output_valid           = res_out.output_valid;
  assign available_force        = res_out.available_force;
  assign height_above_touchdown = res_out.height_above_touchdown;
  assign downward_speed         = res_out.downward_speed;
  assign reference_speed        = res_out.reference_speed;
  assign speed_error            = res_out.speed_error;
  assign commanded_accel        = res_out.commanded_accel;
  assign required_force         = res_out.required_force;
endmodule

FILE: src/ltl_fifo.sv
// Two-entry queue of registered beats.
module ltl_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end
endmodule

FILE: src/ltl_front.sv
// Front end: takes input beats, clamps and classifies them, and queues them.
module ltl_front (
  input  logic                clk,
  input  logic                rst,
  input  ltl_pkg::cfg_t       cfg,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  cg_height,
  input  logic signed [31:0]  vertical_velocity,
  input  logic signed [31:0]  vehicle_mass,
  input  logic signed [31:0]  supply_pressure,
  input  logic                q_pop,
  output logic                q_empty,
  output ltl_pkg::item_t      q_item
);
  import ltl_pkg::*;

  item_t                   item;
  logic signed [32:0]      h_diff;
  logic signed [32:0]      neg_vel;
  logic [$bits(item_t)-1:0] q_vec;

  always_comb begin
    h_diff  = {cg_height[31], cg_height} - $signed({2'b00, cfg.touchdown_cg_height});
    neg_vel = -$signed({vertical_velocity[31], vertical_velocity});

    item.height = h_diff[32] ? 31'd0 : h_diff[30:0];

    if (neg_vel[32]) item.speed = 31'd0;
    else if (neg_vel[31]) item.speed = 31'h7FFF_FFFF;
    else item.speed = neg_vel[30:0];

    if (vehicle_mass < $signed({1'b0, MASS_MIN})) item.mass = MASS_MIN[21:0];
    else if (vehicle_mass > $signed({1'b0, MASS_MAX})) item.mass = MASS_MAX[21:0];
    else item.mass = vehicle_mass[21:0];

    // Pascal readings are scaled down later by a reciprocal multiply in the back end.
    item.pascal = supply_pressure > $signed({1'b0, PASCAL_LIMIT});
    if (item.pascal) item.pressure = supply_pressure[30:0];
    else if (supply_pressure[31]) item.pressure = 31'd0;
    else if (supply_pressure > $signed({1'b0, PRESSURE_MAX_VALID}))
      item.pressure = PRESSURE_MAX_VALID;
    else item.pressure = supply_pressure[30:0];

    item.shutdown = (item.height <= cfg.shutdown_height) &&
                    (item.speed <= cfg.shutdown_speed);
  end

  ltl_fifo #(.WIDTH($bits(item_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_vec),
    .empty (q_empty)
  );

  assign q_item = item_t'(q_vec);
endmodule

FILE: src/ltl_div.sv
// Restoring divider, two quotient bits per cycle.
module ltl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ltl_pkg::DIV_W-1:0]  num,
  input  logic [30:0]                den,
  output logic                       done,
  output logic [ltl_pkg::DIV_W-1:0]  quo
);
  import ltl_pkg::*;

  localparam int STEPS = DIV_W / 2;

  logic [DIV_W-1:0] acc;
  logic [30:0]      rem, dsr, r1, r2;
  logic [31:0]      t1, t2, d1, d2;
  logic             q1, q2, busy;
  logic [4:0]       cnt;

  always_comb begin
    t1 = {rem, acc[DIV_W-1]};
    d1 = t1 - {1'b0, dsr};
    q1 = t1 >= {1'b0, dsr};
    r1 = q1 ? d1[30:0] : t1[30:0];
    t2 = {r1, acc[DIV_W-2]};
    d2 = t2 - {1'b0, dsr};
    q2 = t2 >= {1'b0, dsr};
    r2 = q2 ? d2[30:0] : t2[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits fill in below.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= 31'd0;
      dsr <= den;
    end else if (busy) begin
      acc <= {acc[DIV_W-3:0], q1, q2};
      rem <= r2;
    end
  end

  assign quo = acc;
endmodule

FILE: src/ltl_sqrt.sv
// Bitwise integer square root of a 64-bit value, two result bits per cycle.
module ltl_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ltl_pkg::ROOT_W-1:0] radicand,
  output logic                       done,
  output logic [31:0]                root
);
  import ltl_pkg::*;

  localparam int STEPS = ROOT_W / 4;

  logic [ROOT_W-1:0] x, res, bitv;
  logic [ROOT_W-1:0] s1, x1, res1, bit1, s2, x2, res2;
  logic              ge1, ge2, busy;
  logic [4:0]        cnt;

  always_comb begin
    s1   = res + bitv;
    ge1  = x >= s1;
    x1   = ge1 ? x - s1 : x;
    res1 = ge1 ? (res >> 1) + bitv : res >> 1;
    bit1 = bitv >> 2;
    s2   = res1 + bit1;
    ge2  = x1 >= s2;
    x2   = ge2 ? x1 - s2 : x1;
    res2 = ge2 ? (res1 >> 1) + bit1 : res1 >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      res  <= '0;
      bitv <= {2'b01, {(ROOT_W-2){1'b0}}};
    end else if (busy) begin
      x    <= x2;
      res  <= res2;
      bitv <= bitv >> 4;
    end
  end

  assign root = res[31:0];
endmodule

FILE: src/ltl_back.sv
// Back end: sequencer that runs one queued item through the shared units.
module ltl_back (
  input  logic              clk,
  input  logic              rst,
  input  ltl_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  ltl_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic              out_full,
  output logic              out_push,
  output ltl_pkg::result_t  out_res
);
  import ltl_pkg::*;

  st_t                state, state_next;
  logic               started;

  item_t              it;
  logic [14:0]        pres;
  logic [30:0]        force_av;
  logic               ovalid;
  logic [31:0]        vref;
  logic signed [31:0] verr;
  logic signed [47:0] acmd_raw;
  logic signed [31:0] acmd;
  logic [30:0]        req;
  logic [16:0]        valve;
  logic [61:0]        sq;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_num, div_q;
  logic [30:0]        div_den;

  logic               root_start, root_done;
  logic [ROOT_W-1:0]  root_x;
  logic [31:0]        root;

  logic               p_sat;
  logic [31:0]        verr_mag, g_plus_a, vref_c;
  logic [47:0]        term, req_full;
  logic signed [47:0] acmd_raw_c, aup, neg_g;
  logic [30:0]        req_c;

  // Derived values used by the datapath.
  always_comb begin
    p_sat      = {16'd0, pres} >= cfg.rated_pressure;
    verr_mag   = verr[31] ? (~verr + 32'd1) : verr;
    g_plus_a   = GRAV + acmd;
    term       = {2'b00, mul_p[61:16]};
    acmd_raw_c = verr[31] ? $signed({17'd0, cfg.profile_decel}) - $signed(term)
                          : $signed({17'd0, cfg.profile_decel}) + $signed(term);
    neg_g      = -$signed({16'd0, GRAV});
    aup        = $signed({1'b0, div_q[46:0]}) - $signed({16'd0, GRAV});
    req_full   = mul_p[63:16];
    req_c      = (req_full > {17'd0, force_av}) ? force_av : req_full[30:0];
    root_x     = {2'b00, sq} + {mul_p[62:0], 1'b0};
    if (root < {1'b0, cfg.touchdown_speed}) vref_c = {1'b0, cfg.touchdown_speed};
    else if (root > REFERENCE_SPEED_MAX) vref_c = REFERENCE_SPEED_MAX;
    else vref_c = root;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (!q_empty) state_next = q_item.pascal ? ST_PDIV : ST_FMUL;
      ST_PDIV:  state_next = ST_FMUL;
      ST_FMUL:  state_next = p_sat ? ST_CHECK : ST_FDIV;
      ST_FDIV:  if (div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (force_av < ONE || it.shutdown) state_next = ST_DONE;
        else state_next = ST_SQMUL;
      end
      ST_SQMUL: state_next = ST_TWMUL;
      ST_TWMUL: state_next = ST_ROOT;
      ST_ROOT:  if (root_done) state_next = ST_AMUL;
      ST_AMUL:  state_next = ST_ADIV;
      ST_ADIV:  if (div_done) state_next = ST_RMUL;
      ST_RMUL:  state_next = ST_VDIV;
      ST_VDIV:  if (div_done) state_next = ST_DONE;
      ST_DONE:  if (!out_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == ST_IDLE) && !q_empty;
    out_push   = (state == ST_DONE) && !out_full;
    div_start  = !started && (state == ST_FDIV || state == ST_ADIV || state == ST_VDIV);
    root_start = !started && (state == ST_ROOT);
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    div_num    = '0;
    div_den    = '0;
    case (state)
      // A pascal reading is divided by 100000 through its reciprocal.
      ST_IDLE: begin
        mul_a = {1'b0, q_item.pressure};
        mul_b = PASCAL_RECIP;
      end
      ST_FMUL: begin
        mul_a = {1'b0, cfg.rated_force};
        mul_b = {17'd0, pres};
      end
      ST_FDIV: begin
        div_num = mul_p[DIV_W-1:0];
        div_den = cfg.rated_pressure;
      end
      ST_SQMUL: begin
        mul_a = {1'b0, cfg.touchdown_speed};
        mul_b = {1'b0, cfg.touchdown_speed};
      end
      ST_TWMUL: begin
        mul_a = {1'b0, cfg.profile_decel};
        mul_b = {1'b0, it.height};
      end
      ST_AMUL: begin
        mul_a = {1'b0, cfg.speed_gain};
        mul_b = verr_mag;
      end
      ST_ADIV: begin
        div_num = {1'b0, force_av, 16'd0};
        div_den = {9'd0, it.mass};
      end
      ST_RMUL: begin
        mul_a = {10'd0, it.mass};
        mul_b = g_plus_a;
      end
      ST_VDIV: begin
        div_num = {1'b0, req_c, 16'd0};
        div_den = force_av;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
    end else begin
      state   <= state_next;
      started <= (state_next == state) ? (started | div_start | root_start) : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          it       <= q_item;
          pres     <= q_item.pressure[14:0];
          force_av <= 31'd0;
          ovalid   <= 1'b0;
          vref     <= 32'd0;
          verr     <= 32'sd0;
          acmd     <= 32'sd0;
          req      <= 31'd0;
          valve    <= 17'd0;
        end
      end
      ST_PDIV: begin
        pres <= (mul_p[63:48] > PRESSURE_MAX_VALID[15:0]) ? PRESSURE_MAX_VALID[14:0]
                                                           : mul_p[62:48];
      end
      ST_FMUL:  if (p_sat) force_av <= cfg.rated_force;
      ST_FDIV:  if (div_done) force_av <= div_q[30:0];
      ST_CHECK: ovalid <= force_av >= ONE;
      ST_TWMUL: sq <= mul_p[61:0];
      ST_ROOT: begin
        if (root_done) begin
          vref <= vref_c;
          verr <= $signed({1'b0, it.speed}) - $signed(vref_c);
        end
      end
      ST_ADIV: begin
        if (!started) acmd_raw <= acmd_raw_c;
        if (div_done) begin
          if (acmd_raw < neg_g) acmd <= neg_g[31:0];
          else if (acmd_raw > aup) acmd <= aup[31:0];
          else acmd <= acmd_raw[31:0];
        end
      end
      ST_VDIV: begin
        if (!started) req <= req_c;
        if (div_done) begin
          valve <= (div_q > {31'd0, VALVE_COMMAND_LIMIT}) ? VALVE_COMMAND_LIMIT
                                                           : div_q[16:0];
        end
      end
      default: ;
    endcase
  end

  ltl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  ltl_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_x),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    out_res.valve_command          = valve;
    out_res.output_valid           = ovalid;
    out_res.available_force        = force_av;
    out_res.height_above_touchdown = ovalid ? it.height : 31'd0;
    out_res.downward_speed         = ovalid ? it.speed : 31'd0;
    out_res.reference_speed        = vref[30:0];
    out_res.speed_error            = verr;
    out_res.commanded_accel        = acmd;
    out_res.required_force         = req;
  end
endmodule

FILE: bench/landing_throttle_law_tb.sv
// Self-checking testbench for the landing throttle law block.
`timescale 1ns / 1ps

module landing_throttle_law_tb;
  import ltl_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [31:0] cg;
    logic signed [31:0] vel;
    logic signed [31:0] mass;
    logic signed [31:0] pres;
  } sample_t;

  // Directed row: a sample plus an optional hand-written expectation.
  typedef struct {
    sample_t s;
    bit      typed;
    result_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [31:0] cg_height = '0;
  logic signed [31:0] vertical_velocity = '0;
  logic signed [31:0] vehicle_mass = '0;
  logic signed [31:0] supply_pressure = '0;
  logic empty;
  logic pop = 1'b0;
  logic [16:0] valve_command;
  logic output_valid;
  logic [30:0] available_force;
  logic [30:0] height_above_touchdown;
  logic [30:0] downward_speed;
  logic [30:0] reference_speed;
  logic signed [31:0] speed_error;
  logic signed [31:0] commanded_accel;
  logic [30:0] required_force;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  cfg_t    law_cfg;
  result_t pending_results[$];
  int      errors = 0;
  int      samples_sent = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      config_writes = 0;
  bit      calm_stretch = 1'b0;

  landing_throttle_law u_dut (
    .clk, .rst, .push, .full, .cg_height, .vertical_velocity, .vehicle_mass,
    .supply_pressure, .empty, .pop, .valve_command, .output_valid,
    .available_force, .height_above_touchdown, .downward_speed, .reference_speed,
    .speed_error, .commanded_accel, .required_force, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >> 16;
    return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic result_t throttle_law(sample_t s);
    result_t r;
    logic signed [63:0] m, p, avail, h, vdown, vref, verr, acmd, aup, req, valve, g;
    logic [63:0] sq, tw, sum;
    r = '0;
    g = 64'sd642689;
    m = s.mass;
    if (m < 64'sd1802240) m = 64'sd1802240;
    if (m > 64'sd2293760) m = 64'sd2293760;
    p = s.pres;
    if (p > 64'sd2560000) p = p / 64'sd100000;
    if (p < 0) p = 0;
    if (p > 64'sd20480) p = 64'sd20480;
    if (p >= law_cfg.rated_pressure) avail = law_cfg.rated_force;
    else avail = (64'(law_cfg.rated_force) * 64'(p)) / 64'(law_cfg.rated_pressure);
    r.available_force = avail[30:0];
    if (avail < 64'sd65536) return r;
    h = 64'(s.cg) - 64'(law_cfg.touchdown_cg_height);
    if (h < 0) h = 0;
    vdown = -64'(s.vel);
    if (vdown < 0) vdown = 0;
    if (vdown > 64'sh7FFFFFFF) vdown = 64'sh7FFFFFFF;
    r.height_above_touchdown = h[30:0];
    r.downward_speed = vdown[30:0];
    r.output_valid = 1'b1;
    if (h <= law_cfg.shutdown_height && vdown <= law_cfg.shutdown_speed) return r;
    sq = 64'(law_cfg.touchdown_speed) * 64'(law_cfg.touchdown_speed);
    tw = 64'd2 * 64'(law_cfg.profile_decel) * 64'(h);
    sum = sq + tw;
    if (sum < sq) sum = '1;
    vref = root64(sum);
    if (vref < law_cfg.touchdown_speed) vref = law_cfg.touchdown_speed;
    else if (vref > 64'sd3276800) vref = 64'sd3276800;
    verr = vdown - vref;
    acmd = 64'(law_cfg.profile_decel) + qmul(64'(law_cfg.speed_gain), verr);
    aup = $signed((64'(avail) << 16) / 64'(m)) - g;
    if (acmd < -g) acmd = -g;
    else if (acmd > aup) acmd = aup;
    if (acmd < -64'sh80000000) acmd = -64'sh80000000;
    if (acmd > 64'sh7FFFFFFF) acmd = 64'sh7FFFFFFF;
    req = qmul(m, g + acmd);
    if (req < 0) req = 0;
    if (req > avail) req = avail;
    valve = $signed((64'(req) << 16) / 64'(avail));
    if (valve > 64'sd65536) valve = 64'sd65536;
    r.valve_command = valve[16:0];
    r.reference_speed = vref[30:0];
    r.speed_error = verr[31:0];
    r.commanded_accel = acmd[31:0];
    r.required_force = req[30:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm_stretch && ($urandom_range(99) < 6);
  endfunction

  // Result side: pop at random, compare every accepted beat.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{valve_command, output_valid, available_force, height_above_touchdown,
                downward_speed, reference_speed, speed_error, commanded_accel,
                required_force};
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
      pop <= !idle_now();
    end
  end

  // Watchdog on cycles with no accepted beat of any kind.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TOUCHDOWN_CG_HEIGHT: law_cfg.touchdown_cg_height = value;
      CFG_SHUTDOWN_HEIGHT:     law_cfg.shutdown_height = value;
      CFG_SHUTDOWN_SPEED:      law_cfg.shutdown_speed = value;
      CFG_TOUCHDOWN_SPEED:     law_cfg.touchdown_speed = value;
      CFG_PROFILE_DECEL:       law_cfg.profile_decel = value;
      CFG_SPEED_GAIN:          law_cfg.speed_gain = value;
      CFG_RATED_FORCE:         law_cfg.rated_force = value;
      CFG_RATED_PRESSURE:      law_cfg.rated_pressure = value;
      default: ;
    endcase
    config_writes++;
    @(posedge clk);
  endtask

  task automatic send_sample(sample_t s, bit typed, result_t r);
    while (idle_now()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cg_height <= s.cg;
    vertical_velocity <= s.vel;
    vehicle_mass <= s.mass;
    supply_pressure <= s.pres;
    pending_results.push_back(typed ? r : throttle_law(s));
    do @(posedge clk); while (full);
    samples_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_field();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'sh7FFFFFFF - $urandom_range(3);
      2: return 32'sh80000000 + $urandom_range(3);
      default: return $signed($urandom_range(8000000)) - 32'sd1000000;
    endcase
  endfunction

  // Mostly plausible descent samples, with some arbitrary noise.
  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(9) < 8) begin
      s.cg = $urandom_range(6553600);
      s.vel = -$signed($urandom_range(1600000)) + $signed($urandom_range(130000));
      s.mass = $urandom_range(2500000, 1700000);
      case ($urandom_range(3))
        0: s.pres = $urandom_range(20480);
        1: s.pres = $urandom_range(2048000000, 2560001);
        2: s.pres = $urandom_range(300);
        default: s.pres = $urandom_range(14000, 11000);
      endcase
    end else begin
      s = '{pick_field(), pick_field(), pick_field(), pick_field()};
    end
    return s;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 100) calm_stretch = 1'b1;
      if (i % 200 == 160) calm_stretch = 1'b0;
      send_sample(random_sample(), 1'b0, '0);
    end
    calm_stretch = 1'b0;
    drain();
  endtask

  row_t rows[$];
  result_t low;

  initial begin
    law_cfg = '{31'd32768, 31'd3277, 31'd19661, 31'd65536, 31'd196608, 31'd65536,
                31'd39321600, 31'd12800};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero pressure leaves no thrust at all; the result is marked not valid.
    low = '0;
    rows.push_back('{'{32'sd100000, -32'sd100000, 32'sd2000000, 32'sd0}, 1'b1, low});
    rows.push_back('{'{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b1, low});
    // Rated pressure gives the rated force inside the shutdown window: valve closed.
    low = '0;
    low.output_valid = 1'b1;
    low.available_force = 31'd39321600;
    rows.push_back('{'{32'sd32768, 32'sd0, 32'sd2000000, 32'sd12800}, 1'b1, low});
    rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 32'sd20480}, 1'b1, low});
    rows.push_back('{'{32'sd35000, -32'sd19661, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '0});
    rows.push_back('{'{32'sd35000, -32'sd19662, 32'sd1, 32'sd12799}, 0, '0});
    rows.push_back('{'{32'sh7FFFFFFF, 32'sh80000000, 32'sd2000000, 32'sd12800}, 0, '0});
    rows.push_back('{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd2293760, 32'sd2560000}, 0, '0});
    rows.push_back('{'{32'sd655360, -32'sd655360, 32'sd1802240, 32'sd2560001}, 0, '0});
    rows.push_back('{'{32'sd655360, -32'sd65536, 32'sd2000000, 32'sd26000000}, 0, '0});
    rows.push_back('{'{32'sd655360, -32'sd3000000, 32'sd2000000, 32'sd21}, 0, '0});
    rows.push_back('{'{32'sd6553600, 32'sd65536, 32'sd2000000, 32'sd6400}, 0, '0});
    rows.push_back('{'{32'sd6553600, -32'sd99999, 32'sd2293761, 32'sd12800}, 0, '0});
    rows.push_back('{'{32'sd3000000, -32'sd500000, 32'sd1802239, 32'sd1}, 0, '0});
    foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].r);
    drain();
    random_phase(500);

    // Extremes of every register.
    write_reg(CFG_TOUCHDOWN_CG_HEIGHT, '0);
    write_reg(CFG_SHUTDOWN_HEIGHT, '0);
    write_reg(CFG_SHUTDOWN_SPEED, '0);
    write_reg(CFG_TOUCHDOWN_SPEED, '0);
    write_reg(CFG_PROFILE_DECEL, '1);
    write_reg(CFG_SPEED_GAIN, '1);
    write_reg(CFG_RATED_FORCE, '1);
    write_reg(CFG_RATED_PRESSURE, 31'd1);
    random_phase(300);

    // Touchdown speed above the reference cap, a tiny force and zero gain.
    write_reg(CFG_TOUCHDOWN_SPEED, '1);
    write_reg(CFG_PROFILE_DECEL, '0);
    write_reg(CFG_SPEED_GAIN, '0);
    write_reg(CFG_RATED_FORCE, 31'd70000);
    write_reg(CFG_RATED_PRESSURE, '1);
    write_reg(CFG_SHUTDOWN_HEIGHT, '1);
    write_reg(CFG_TOUCHDOWN_CG_HEIGHT, '1);
    random_phase(300);

    // Random settings around the nominal ones.
    for (int k = 0; k < 3; k++) begin
      write_reg(CFG_TOUCHDOWN_CG_HEIGHT, 31'($urandom_range(200000)));
      write_reg(CFG_SHUTDOWN_HEIGHT, 31'($urandom_range(100000)));
      write_reg(CFG_SHUTDOWN_SPEED, 31'($urandom_range(100000)));
      write_reg(CFG_TOUCHDOWN_SPEED, 31'($urandom_range(4000000)));
      write_reg(CFG_PROFILE_DECEL, 31'($urandom_range(2000000)));
      write_reg(CFG_SPEED_GAIN, 31'($urandom_range(400000)));
      write_reg(CFG_RATED_FORCE, 31'($urandom_range(80000000)));
      write_reg(CFG_RATED_PRESSURE, 31'($urandom_range(30000, 1)));
      random_phase(200);
    end

    $display("%0d samples, %0d results, %0d register writes over six register setups",
             samples_sent, results_seen, config_writes);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ltl_pkg.sv
src/ltl_fifo.sv
src/ltl_front.sv
src/ltl_div.sv
src/ltl_sqrt.sv
src/ltl_back.sv
src/landing_throttle_law.sv
bench/landing_throttle_law_tb.sv
